@@ sv/m68k_effective_address_unit_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the effective address unit.
// ---------------------------------------------------------------------------
`ifndef M68K_EFFECTIVE_ADDRESS_UNIT_CORE_DEFINES_SVH
`define M68K_EFFECTIVE_ADDRESS_UNIT_CORE_DEFINES_SVH

`define EAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define EAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/m68kea_pkg.sv @@
// ---------------------------------------------------------------------------
// m68kea_pkg
// Types, codes and helpers for the effective address unit.
// ---------------------------------------------------------------------------
package m68kea_pkg;

   localparam int QueueDepth = 2;

   localparam logic [1:0] REQ_COMPUTE  = 2'd0;
   localparam logic [1:0] REQ_POINTER  = 2'd1;
   localparam logic [1:0] REQ_ACCESS   = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic [2:0] KIND_ADDR     = 3'd0;
   localparam logic [2:0] KIND_PTR      = 3'd1;
   localparam logic [2:0] KIND_RDATA    = 3'd2;
   localparam logic [2:0] KIND_RWRITTEN = 3'd3;
   localparam logic [2:0] KIND_MEM      = 3'd4;
   localparam logic [2:0] KIND_INVALID  = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  ea_mode;
      logic [2:0]  ea_reg;
      logic [1:0]  op_size;
      logic        write_flag;
      logic [15:0] ext_first;
      logic [63:0] ext_rest;
      logic [31:0] pc_value;
      logic [31:0] access_address;
      logic [31:0] data_value;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] out_address;
      logic [3:0]  ext_bytes;
      logic [31:0] out_data;
      logic [1:0]  mem_size;
      logic        mem_write;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_INVALID, OP_ZERO, OP_AREG, OP_PREDEC, OP_DISP, OP_INDEX, OP_POINTER, OP_ACCESS
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        clear_pend;
      logic        pc_base;
      logic [2:0]  ea_mode;
      logic [2:0]  ea_reg;
      logic [1:0]  op_size;
      logic        write_flag;
      logic [15:0] ext_first;
      logic [63:0] ext_rest;
      logic [31:0] pc_value;
      logic [31:0] access_address;
      logic [31:0] data_value;
   } cmd_type;

   function automatic logic [31:0] step_size(input logic [1:0] size, input logic [2:0] rn);
      if (size == 2'd0) return (rn == 3'd7) ? 32'd2 : 32'd1;
      return (size == 2'd1) ? 32'd2 : 32'd4;
   endfunction

endpackage

@@ sv/m68kea_front.sv @@
// ---------------------------------------------------------------------------
// m68kea_front
// Accepts request words and classifies them into back-end commands.
// ---------------------------------------------------------------------------
module m68kea_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  m68kea_pkg::req_type_type req_payload,
   output logic                   cmd_valid,
   input  logic                   cmd_stall,
   output m68kea_pkg::cmd_type    cmd_payload
);
   logic                valid_ff, valid_in;
   m68kea_pkg::cmd_type cmd_ff, cmd_in;
   m68kea_pkg::req_type_type r;

   assign r = req_payload;
   assign req_stall = valid_ff && cmd_stall;

   always_comb begin
      cmd_in = '{op: m68kea_pkg::OP_INVALID,
                 clear_pend: (r.req_type == m68kea_pkg::REQ_COMPUTE),
                 pc_base: 1'b0, ea_mode: r.ea_mode,
                 ea_reg: r.ea_reg, op_size: r.op_size, write_flag: r.write_flag,
                 ext_first: r.ext_first, ext_rest: r.ext_rest, pc_value: r.pc_value,
                 access_address: r.access_address, data_value: r.data_value};
      unique case (r.req_type)
         m68kea_pkg::REQ_COMPUTE: begin
            unique case (r.ea_mode)
               3'd0, 3'd1: cmd_in.op = m68kea_pkg::OP_ZERO;
               3'd2, 3'd3: cmd_in.op = m68kea_pkg::OP_AREG;
               3'd4: cmd_in.op = (r.op_size == 2'd3) ? m68kea_pkg::OP_INVALID
                                                     : m68kea_pkg::OP_PREDEC;
               3'd5: cmd_in.op = m68kea_pkg::OP_DISP;
               3'd6: cmd_in.op = m68kea_pkg::OP_INDEX;
               default: begin
                  cmd_in.pc_base = 1'b1;
                  if (r.ea_reg == 3'd2) cmd_in.op = m68kea_pkg::OP_DISP;
                  else if (r.ea_reg == 3'd3) cmd_in.op = m68kea_pkg::OP_INDEX;
                  else cmd_in.op = m68kea_pkg::OP_INVALID;
               end
            endcase
         end
         m68kea_pkg::REQ_POINTER: cmd_in.op = m68kea_pkg::OP_POINTER;
         m68kea_pkg::REQ_ACCESS: cmd_in.op = (r.op_size == 2'd3) ? m68kea_pkg::OP_INVALID
                                                               : m68kea_pkg::OP_ACCESS;
         m68kea_pkg::REQ_RESERVED: cmd_in.op = m68kea_pkg::OP_INVALID;
      endcase
      valid_in = valid_ff;
      if (!req_stall) valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (!req_stall) cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd_payload = cmd_ff;
endmodule

@@ sv/m68kea_queue.sv @@
// ---------------------------------------------------------------------------
// m68kea_queue
// Short command queue between the front and back ends.
// ---------------------------------------------------------------------------
module m68kea_queue #(
   parameter int Depth = m68kea_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  m68kea_pkg::cmd_type in_payload,
   output logic                out_valid,
   input  logic                out_stall,
   output m68kea_pkg::cmd_type out_payload
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   m68kea_pkg::cmd_type mem [Depth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_stall = (cnt_ff == (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;
   assign out_payload = mem[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) wp_in = (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
      if (pop) rp_in = (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem[wp_ff] <= in_payload;
   end
endmodule

@@ sv/m68kea_back.sv @@
// ---------------------------------------------------------------------------
// m68kea_back
// Register file, address arithmetic and the result register.
// ---------------------------------------------------------------------------
module m68kea_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_stall,
   input  m68kea_pkg::cmd_type cmd_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output m68kea_pkg::rsp_type rsp_payload
);
   logic [31:0] dreg_ff [8];
   logic [31:0] areg_ff [8];
   logic        pend_ff, pend_in;
   logic [31:0] addend_ff, addend_in;
   logic [3:0]  pbytes_ff, pbytes_in;
   logic        valid_ff, valid_in;
   m68kea_pkg::rsp_type rsp_ff, rsp_in;
   logic        go;
   logic        dwe, awe;
   logic [31:0] wval;
   logic [2:0]  wn;
   m68kea_pkg::cmd_type c;

   logic [15:0] w [5];
   logic [31:0] areg, base, idxv, bd, od, b, idx, ptr, rv, mask, stp;
   logic [2:0]  xn, iis;
   logic [1:0]  bdsz;
   logic [2:0]  pos;
   logic        isup, post;

   assign c = cmd_payload;
   assign cmd_stall = valid_ff && rsp_stall;
   assign go = cmd_valid && !cmd_stall;

   always_comb begin
      w[0] = c.ext_first;
      w[1] = c.ext_rest[63:48];
      w[2] = c.ext_rest[47:32];
      w[3] = c.ext_rest[31:16];
      w[4] = c.ext_rest[15:0];
      areg = areg_ff[c.ea_reg];
      base = c.pc_base ? c.pc_value : areg;
      stp = m68kea_pkg::step_size(c.op_size, c.ea_reg);
      xn = c.ext_first[14:12];
      idxv = c.ext_first[15] ? areg_ff[xn] : dreg_ff[xn];
      if (!c.ext_first[11]) idxv = {{16{idxv[15]}}, idxv[15:0]};
      idxv = idxv << c.ext_first[10:9];
      bdsz = c.ext_first[5:4];
      iis = c.ext_first[2:0];
      isup = c.ext_first[6];
      post = iis[2];
      pos = 3'd1;
      bd = '0;
      if (bdsz == 2'd2) begin
         bd = {{16{w[1][15]}}, w[1]};
         pos = 3'd2;
      end else if (bdsz == 2'd3) begin
         bd = {w[1], w[2]};
         pos = 3'd3;
      end
      od = '0;
      if (iis[1:0] == 2'd2) od = {{16{w[pos][15]}}, w[pos]};
      else if (iis[1:0] == 2'd3) od = {w[pos], w[3'(pos + 3'd1)]};
      b = c.ext_first[7] ? 32'd0 : base;
      idx = isup ? 32'd0 : idxv;
      ptr = b + bd + (post ? 32'd0 : idx);
      mask = (c.op_size == 2'd0) ? 32'hFF : (c.op_size == 2'd1) ? 32'hFFFF : 32'hFFFFFFFF;
      rv = (c.ea_mode == 3'd0) ? dreg_ff[c.ea_reg] : areg;
      wval = (rv & ~mask) | (c.data_value & mask);
      wn = c.ea_reg;
      dwe = 1'b0;
      awe = 1'b0;

      rsp_in = '{result_kind: m68kea_pkg::KIND_INVALID, default: '0};
      pend_in = pend_ff;
      addend_in = addend_ff;
      pbytes_in = pbytes_ff;
      if (c.clear_pend) begin
         pend_in = 1'b0;
         addend_in = '0;
         pbytes_in = '0;
      end
      unique case (c.op)
         m68kea_pkg::OP_ZERO: rsp_in.result_kind = m68kea_pkg::KIND_ADDR;
         m68kea_pkg::OP_AREG: begin
            rsp_in.result_kind = m68kea_pkg::KIND_ADDR;
            rsp_in.out_address = areg;
         end
         m68kea_pkg::OP_PREDEC: begin
            rsp_in.result_kind = m68kea_pkg::KIND_ADDR;
            rsp_in.out_address = areg - stp;
         end
         m68kea_pkg::OP_DISP: begin
            rsp_in.result_kind = m68kea_pkg::KIND_ADDR;
            rsp_in.out_address = base + {{16{w[0][15]}}, w[0]};
            rsp_in.ext_bytes = 4'd2;
         end
         m68kea_pkg::OP_INDEX: begin
            if (!c.ext_first[8]) begin
               rsp_in.result_kind = m68kea_pkg::KIND_ADDR;
               rsp_in.out_address = base + idxv + {{24{w[0][7]}}, w[0][7:0]};
               rsp_in.ext_bytes = 4'd2;
            end else if (bdsz == 2'd0 || (isup && iis[2]) || (!isup && iis == 3'd4)) begin
               rsp_in.result_kind = m68kea_pkg::KIND_INVALID;
            end else if (iis == 3'd0) begin
               rsp_in.result_kind = m68kea_pkg::KIND_ADDR;
               rsp_in.out_address = b + bd + idx;
               rsp_in.ext_bytes = {pos, 1'b0};
            end else begin
               rsp_in.result_kind = m68kea_pkg::KIND_PTR;
               rsp_in.out_address = ptr;
               rsp_in.ext_bytes = {pos + {1'b0, iis[1:0] == 2'd3, iis[1:0] == 2'd2}, 1'b0};
               pend_in = 1'b1;
               addend_in = od + (post ? idx : 32'd0);
               pbytes_in = rsp_in.ext_bytes;
            end
         end
         m68kea_pkg::OP_POINTER: begin
            if (pend_ff) begin
               rsp_in.result_kind = m68kea_pkg::KIND_ADDR;
               rsp_in.out_address = c.data_value + addend_ff;
               rsp_in.ext_bytes = pbytes_ff;
               pend_in = 1'b0;
               addend_in = '0;
               pbytes_in = '0;
            end
         end
         m68kea_pkg::OP_ACCESS: begin
            if (c.ea_mode == 3'd0 || c.ea_mode == 3'd1) begin
               if (c.write_flag) begin
                  rsp_in.result_kind = m68kea_pkg::KIND_RWRITTEN;
                  dwe = (c.ea_mode == 3'd0);
                  awe = (c.ea_mode == 3'd1);
               end else begin
                  rsp_in.result_kind = m68kea_pkg::KIND_RDATA;
                  rsp_in.out_data = rv & mask;
               end
            end else begin
               rsp_in.result_kind = m68kea_pkg::KIND_MEM;
               rsp_in.out_address = c.access_address;
               rsp_in.out_data = c.write_flag ? c.data_value : 32'd0;
               rsp_in.mem_size = c.op_size;
               rsp_in.mem_write = c.write_flag;
               if (c.ea_mode == 3'd4) begin
                  awe = 1'b1;
                  wval = areg - stp;
               end else if (c.ea_mode == 3'd3) begin
                  awe = 1'b1;
                  wval = areg + stp;
               end
            end
         end
         default: rsp_in.result_kind = m68kea_pkg::KIND_INVALID;
      endcase
      valid_in = valid_ff;
      if (!cmd_stall) valid_in = cmd_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         addend_ff <= '0;
         pbytes_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            dreg_ff[i] <= '0;
            areg_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (go) begin
            pend_ff <= pend_in;
            addend_ff <= addend_in;
            pbytes_ff <= pbytes_in;
         end
         if (go && dwe) dreg_ff[wn] <= wval;
         if (go && awe) areg_ff[wn] <= wval;
      end
      if (!cmd_stall) rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

@@ sv/m68k_effective_address_unit_core.sv @@
// ---------------------------------------------------------------------------
// m68k_effective_address_unit_core
// 68020 effective address unit with D0-D7/A0-A7 register file.
// ---------------------------------------------------------------------------
// One request word per cycle is accepted unless req_stall is high, and each
// yields one response word. The path holds a classify register, a short
// command queue and the result register after the address adders and the
// register file; register updates land when the command leaves the queue, so
// back-to-back requests see earlier writes.
`include "m68k_effective_address_unit_core_defines.svh"
module m68k_effective_address_unit_core #(
   parameter int QueueDepth = m68kea_pkg::QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  m68kea_pkg::req_type_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output m68kea_pkg::rsp_type      rsp_payload
);
   logic f_valid, f_stall, q_valid, q_stall;
   m68kea_pkg::cmd_type f_cmd, q_cmd;

   m68kea_front u_front (.clock, .reset, .req_valid, .req_stall, .req_payload,
      .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd_payload(f_cmd));
   m68kea_queue #(.Depth(QueueDepth)) u_queue (.clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_payload(f_cmd),
      .out_valid(q_valid), .out_stall(q_stall), .out_payload(q_cmd));
   m68kea_back u_back (.clock, .reset, .cmd_valid(q_valid), .cmd_stall(q_stall),
      .cmd_payload(q_cmd), .rsp_valid, .rsp_stall, .rsp_payload);

   `EAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `EAU_ASSERT_IMPL(a_kind_range, clock, reset, rsp_valid, rsp_payload.result_kind <= m68kea_pkg::KIND_INVALID)
   `EAU_ASSERT_IMPL(a_q_flow, clock, reset, q_valid && !q_stall, !(rsp_valid && rsp_stall))
endmodule
